// ===== rtl/sbb_pkg.sv =====
// Package for the separable box blur unit: payload structs, status codes,
// register indexes and default sizes. No dependencies.
package sbb_pkg;

  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned DefMaxRadius = 31;

  typedef enum logic [1:0] {
    StatPixel     = 2'd0,
    StatLoadOk    = 2'd1,
    StatReadEarly = 2'd2,
    StatLoadFull  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegRadius = 2'd0,
    RegWidth  = 2'd1,
    RegHeight = 2'd2
  } reg_idx_e;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } out_item_t;

endpackage

// ===== rtl/separable_box_blur_rgb_unit.sv =====
// Top level of the separable RGB box blur unit with clamped edges.
// Depends on sbb_pkg. Holds the frame memory, the row-pass memory and the sequencer.

// A frame is loaded one pixel per beat in raster order. A load, an early read or
// a load into a full frame passes through the start and output states, and a pixel
// read also through a read state. The beat that completes the frame starts the blur,
// unless the radius is zero. The blur walks both memories through one shared
// accumulator and one shared restoring divider. Each output pixel of each pass
// takes an address state, then the accumulate state (one memory read per cycle),
// then the divider state (one step per bit of the sum), then a write and a
// turnaround state. The input is not ready while the blur runs. Reads then return
// the blurred pixels in raster order, and the last one is flagged.
module separable_box_blur_rgb_unit #(
  parameter int unsigned MaxWidth  = sbb_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = sbb_pkg::DefMaxHeight,
  parameter int unsigned MaxRadius = sbb_pkg::DefMaxRadius
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sbb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbb_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WW    = $clog2(MaxWidth + 1);
  localparam int unsigned HW    = $clog2(MaxHeight + 1);
  localparam int unsigned CW    = 13;
  localparam int unsigned DimW  = (WW > HW) ? WW : HW;
  localparam int unsigned RW    = $clog2(MaxRadius + 1);
  localparam int unsigned WinW  = RW + 2;
  localparam int unsigned SW    = 8 + WinW;
  localparam int unsigned DivN  = SW;
  localparam int unsigned DcW   = $clog2(DivN + 1);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StStart = 9'b000000010,
    StAddr  = 9'b000000100,
    StAcc   = 9'b000001000,
    StDiv   = 9'b000010000,
    StWrite = 9'b000100000,
    StRead  = 9'b001000000,
    StOut   = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] radius_q;
  logic [6:0] width_q, height_q;

  logic [23:0] frame_mem [Depth];
  logic [23:0] row_mem   [Depth];

  logic [CW-1:0] load_cnt_q, read_cnt_q;
  logic          full_q;
  logic          pass_q;
  logic [DimW-1:0] pos_q, line_q;
  logic [RW:0]   tap_q;
  logic [SW-1:0] sum_q [3];
  logic [SW-1:0] rem_q [3];
  logic [SW-1:0] quo_q [3];
  logic [DcW-1:0] dcnt_q;
  logic [23:0]   rd_q;
  logic          rd_src_q;
  logic          rd_vld_q;
  logic          last_acc_q;
  sbb_pkg::in_item_t  item_q;
  sbb_pkg::out_item_t out_q;

  // Effective register values.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] eff_r;
  logic [CW-1:0] n_pix;
  always_comb begin
    if (width_q == 7'd0) eff_w = WW'(1);
    else if (32'(width_q) > MaxWidth) eff_w = WW'(MaxWidth);
    else eff_w = WW'(width_q);
    if (height_q == 7'd0) eff_h = HW'(1);
    else if (32'(height_q) > MaxHeight) eff_h = HW'(MaxHeight);
    else eff_h = HW'(height_q);
    if (32'(radius_q) > MaxRadius) eff_r = RW'(MaxRadius);
    else eff_r = RW'(radius_q);
    n_pix = CW'(32'(eff_w) * 32'(eff_h));
  end

  logic [RW:0] tap_last;
  logic        acc_more;
  assign tap_last = (RW+1)'({eff_r, 1'b0}) + (RW+1)'(1);
  assign acc_more = (tap_q != tap_last) && !last_acc_q;

  // Window addressing: d = tap - r, index clamped to [0, top].
  logic signed [DimW+RW+1:0] idx_s;
  logic [DimW-1:0] idx_c, top_c;
  logic [AW-1:0]   mem_addr, wr_addr;
  logic [WinW-1:0] win;
  always_comb begin
    top_c = pass_q ? DimW'(eff_h - HW'(1)) : DimW'(eff_w - WW'(1));
    idx_s = $signed({{(RW+2){1'b0}}, pos_q}) + $signed({{(DimW+1){1'b0}}, tap_q})
          - $signed({{(DimW+2){1'b0}}, eff_r});
    if (idx_s < 0) idx_c = '0;
    else if (idx_s > $signed({2'b00, {RW{1'b0}}, top_c})) idx_c = top_c;
    else idx_c = idx_s[DimW-1:0];
    if (pass_q) begin
      mem_addr = AW'(32'(idx_c) * 32'(eff_w) + 32'(line_q));
      wr_addr  = AW'(32'(pos_q) * 32'(eff_w) + 32'(line_q));
    end else begin
      mem_addr = AW'(32'(line_q) * 32'(eff_w) + 32'(idx_c));
      wr_addr  = AW'(32'(line_q) * 32'(eff_w) + 32'(pos_q));
    end
    win = WinW'({eff_r, 1'b1});
  end

  // Memories.
  logic          fm_we, rm_we;
  logic [AW-1:0] fm_waddr, rd_addr;
  logic [23:0]   fm_wdata, fm_rdata, rm_rdata;
  logic [23:0]   quo_px;
  assign quo_px = {quo_q[0][7:0], quo_q[1][7:0], quo_q[2][7:0]};

  always_ff @(posedge clk_i) begin
    if (fm_we) frame_mem[fm_waddr] <= fm_wdata;
    if (rm_we) row_mem[wr_addr] <= quo_px;
    fm_rdata <= frame_mem[rd_addr];
    rm_rdata <= row_mem[rd_addr];
  end

  always_comb begin
    fm_we    = 1'b0;
    rm_we    = 1'b0;
    fm_waddr = wr_addr;
    fm_wdata = quo_px;
    rd_addr  = (state_q == StStart) ? read_cnt_q[AW-1:0] : mem_addr;
    if (state_q == StStart && item_q.operation == sbb_pkg::OpLoad && !full_q &&
        32'(load_cnt_q) < Depth) begin
      fm_we    = 1'b1;
      fm_waddr = load_cnt_q[AW-1:0];
      fm_wdata = {item_q.in_red, item_q.in_green, item_q.in_blue};
    end else if (state_q == StWrite) begin
      fm_we = pass_q;
      rm_we = !pass_q;
    end
  end

  assign rd_q = rd_src_q ? rm_rdata : fm_rdata;

  // Shared divider step, one per channel lane.
  logic [SW:0]   trial [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_q[c], quo_q[c][SW-1]} - (SW+1)'(win);
    end
  end

  logic [CW-1:0] load_next;
  assign load_next = (load_cnt_q != {CW{1'b1}}) ? load_cnt_q + CW'(1) : load_cnt_q;

  logic pass_end, all_end;
  assign pass_end = (pos_q == top_c) &&
                    (line_q == (pass_q ? DimW'(eff_w - WW'(1)) : DimW'(eff_h - HW'(1))));
  assign all_end = pass_end && pass_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StStart;
      StStart: begin
        if (item_q.operation == sbb_pkg::OpLoad) begin
          if (!full_q && load_next >= n_pix && eff_r != '0) state_d = StAddr;
          else state_d = StOut;
        end else if (full_q) begin
          state_d = StRead;
        end else begin
          state_d = StOut;
        end
      end
      StAddr:  state_d = StAcc;
      StAcc:   if (last_acc_q) state_d = StDiv;
      StDiv:   if (dcnt_q == DcW'(1)) state_d = StWrite;
      StWrite: state_d = all_end ? StOut : StDone;
      StDone:  state_d = StAddr;
      StRead:  state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      radius_q   <= 5'd1;
      width_q    <= 7'd64;
      height_q   <= 7'd64;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      full_q     <= 1'b0;
      pass_q     <= 1'b0;
      pos_q      <= '0;
      line_q     <= '0;
      tap_q      <= '0;
      dcnt_q     <= '0;
      rd_src_q   <= 1'b0;
      rd_vld_q   <= 1'b0;
      last_acc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          sbb_pkg::RegRadius: radius_q <= pwdata[4:0];
          sbb_pkg::RegWidth:  width_q  <= pwdata[6:0];
          sbb_pkg::RegHeight: height_q <= pwdata[6:0];
          default: ;
        endcase
      end
      rd_vld_q <= (state_q == StAddr) || (state_q == StAcc && acc_more);
      case (state_q)
        StStart: begin
          if (item_q.operation == sbb_pkg::OpLoad && !full_q) begin
            load_cnt_q <= load_next;
            if (load_next >= n_pix) full_q <= 1'b1;
          end else if (item_q.operation == sbb_pkg::OpRead && full_q) begin
            if (32'(read_cnt_q) + 1 >= 32'(n_pix)) begin
              read_cnt_q <= '0;
              load_cnt_q <= '0;
              full_q     <= 1'b0;
            end else begin
              read_cnt_q <= read_cnt_q + CW'(1);
            end
          end
          pass_q   <= 1'b0;
          pos_q    <= '0;
          line_q   <= '0;
          tap_q    <= '0;
          rd_src_q <= 1'b0;
        end
        StAddr: begin
          tap_q      <= tap_q + (RW+1)'(1);
          last_acc_q <= 1'b0;
        end
        StAcc: begin
          if (acc_more) begin
            tap_q <= tap_q + (RW+1)'(1);
          end else begin
            last_acc_q <= 1'b1;
          end
          dcnt_q <= DcW'(DivN);
        end
        StDiv: dcnt_q <= dcnt_q - DcW'(1);
        StWrite: begin
          tap_q <= '0;
          if (pos_q == top_c) begin
            pos_q <= '0;
            if (pass_end) begin
              line_q   <= '0;
              pass_q   <= 1'b1;
              rd_src_q <= 1'b1;
            end else begin
              line_q <= line_q + DimW'(1);
            end
          end else begin
            pos_q <= pos_q + DimW'(1);
          end
        end
        StDone: ;
        default: ;
      endcase
    end
  end

  function automatic logic trial_first(input logic [SW-1:0] s, input logic [WinW-1:0] w);
    trial_first = (SW'(s[SW-1]) >= SW'(w));
  endfunction

  // Accumulator and divider datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StAddr: for (int c = 0; c < 3; c++) sum_q[c] <= '0;
      StAcc: begin
        if (rd_vld_q) begin
          sum_q[0] <= sum_q[0] + SW'(rd_q[23:16]);
          sum_q[1] <= sum_q[1] + SW'(rd_q[15:8]);
          sum_q[2] <= sum_q[2] + SW'(rd_q[7:0]);
        end
        for (int c = 0; c < 3; c++) rem_q[c] <= '0;
      end
      StDiv: begin
        for (int c = 0; c < 3; c++) begin
          if (dcnt_q == DcW'(DivN)) begin
            if (!trial_first(sum_q[c], win)) begin
              rem_q[c] <= SW'(sum_q[c][SW-1]);
            end else begin
              rem_q[c] <= SW'({sum_q[c][SW-1]} - 1'b0) - SW'(win);
            end
            quo_q[c] <= {sum_q[c][SW-2:0], trial_first(sum_q[c], win)};
          end else if (!trial[c][SW]) begin
            rem_q[c] <= trial[c][SW-1:0];
            quo_q[c] <= {quo_q[c][SW-2:0], 1'b1};
          end else begin
            rem_q[c] <= {rem_q[c][SW-2:0], quo_q[c][SW-1]};
            quo_q[c] <= {quo_q[c][SW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  sbb_pkg::out_item_t out_start;
  always_comb begin
    out_start = '0;
    if (item_q.operation == sbb_pkg::OpLoad) begin
      out_start.status = full_q ? sbb_pkg::StatLoadFull : sbb_pkg::StatLoadOk;
    end else if (!full_q) begin
      out_start.status = sbb_pkg::StatReadEarly;
    end else begin
      out_start.status     = sbb_pkg::StatPixel;
      out_start.last_pixel = (32'(read_cnt_q) + 1 >= 32'(n_pix));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    if (state_q == StStart) out_q <= out_start;
    if (state_q == StRead) begin
      out_q.out_red   <= fm_rdata[23:16];
      out_q.out_green <= fm_rdata[15:8];
      out_q.out_blue  <= fm_rdata[7:0];
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;
  assign pready      = 1'b1;

  always_comb begin
    case (paddr[3:2])
      sbb_pkg::RegRadius: prdata = {27'd0, radius_q};
      sbb_pkg::RegWidth:  prdata = {25'd0, width_q};
      sbb_pkg::RegHeight: prdata = {25'd0, height_q};
      default:            prdata = '0;
    endcase
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StStart) else $error("accept lost");
  a_out_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("no return to idle");
  a_pixel_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> $past(full_q)) else $error("read of partial frame");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for separable_box_blur_rgb_unit: it loads frames, blurs them
// and reads them back under random stalls, comparing every beat with its own blur model.
// Depends on sbb_pkg and the unit's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = sbb_pkg::DefMaxWidth * sbb_pkg::DefMaxHeight;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sbb_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sbb_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  separable_box_blur_rgb_unit dut (.*);

  always #4 clk_i = ~clk_i;

  sbb_pkg::in_item_t pending_beats[$];
  sbb_pkg::out_item_t expected_pixels[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  logic [23:0] src_mem[Depth];
  logic [23:0] row_mem[Depth];
  int unsigned cfg_radius = 1, cfg_width = 64, cfg_height = 64;
  int unsigned loaded = 0, read_idx = 0;
  bit frame_done = 0;

  function automatic bit quiet_now();
    return cycle_count > 20000 && cycle_count < 26000;
  endfunction

  function automatic int unsigned eff_w();
    return cfg_width == 0 ? 1 :
           (cfg_width > sbb_pkg::DefMaxWidth ? sbb_pkg::DefMaxWidth : cfg_width);
  endfunction

  function automatic int unsigned eff_h();
    return cfg_height == 0 ? 1 :
           (cfg_height > sbb_pkg::DefMaxHeight ? sbb_pkg::DefMaxHeight : cfg_height);
  endfunction

  function automatic logic [23:0] box_mean(bit from_rows, int base, int step, int pos,
                                           int top, int r);
    int sum[3];
    int idx, p;
    logic [23:0] px;
    sum = '{0, 0, 0};
    for (int d = -r; d <= r; d++) begin
      p = pos + d;
      if (p < 0) p = 0;
      if (p > top) p = top;
      idx = (base + p * step) % Depth;
      px = from_rows ? row_mem[idx] : src_mem[idx];
      sum[0] += px[23:16];
      sum[1] += px[15:8];
      sum[2] += px[7:0];
    end
    return {8'(sum[0] / (2 * r + 1)), 8'(sum[1] / (2 * r + 1)), 8'(sum[2] / (2 * r + 1))};
  endfunction

  function automatic void blur_frame();
    int w, h, r;
    w = eff_w();
    h = eff_h();
    r = cfg_radius;
    if (r == 0) return;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        row_mem[y * w + x] = box_mean(0, y * w, 1, x, w - 1, r);
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h; y++)
        src_mem[y * w + x] = box_mean(1, x, w, y, h - 1, r);
  endfunction

  function automatic sbb_pkg::out_item_t predict_blur_step(sbb_pkg::in_item_t it);
    sbb_pkg::out_item_t res;
    int unsigned n;
    res = '0;
    n = eff_w() * eff_h();
    if (it.operation == sbb_pkg::OpLoad) begin
      if (frame_done) begin
        res.status = sbb_pkg::StatLoadFull;
        return res;
      end
      src_mem[loaded] = {it.in_red, it.in_green, it.in_blue};
      loaded++;
      if (loaded >= n) begin
        frame_done = 1;
        blur_frame();
      end
      res.status = sbb_pkg::StatLoadOk;
      return res;
    end
    if (!frame_done) begin
      res.status = sbb_pkg::StatReadEarly;
      return res;
    end
    res.status = sbb_pkg::StatPixel;
    {res.out_red, res.out_green, res.out_blue} = src_mem[read_idx];
    if (read_idx + 1 >= n) begin
      res.last_pixel = 1'b1;
      read_idx = 0;
      loaded = 0;
      frame_done = 0;
    end else begin
      read_idx++;
    end
    return res;
  endfunction

  task automatic send(logic op, logic [23:0] rgb);
    sbb_pkg::in_item_t it;
    it.operation = op;
    {it.in_red, it.in_green, it.in_blue} = rgb;
    expected_pixels.push_back(predict_blur_step(it));
    pending_beats.push_back(it);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || expected_pixels.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(sbb_pkg::reg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int unsigned r, int unsigned w, int unsigned h);
    drain();
    write_reg(sbb_pkg::RegRadius, r);
    write_reg(sbb_pkg::RegWidth, w);
    write_reg(sbb_pkg::RegHeight, h);
    cfg_radius = r & 5'h1f;
    cfg_width = w & 7'h7f;
    cfg_height = h & 7'h7f;
  endtask

  // mode 0 random pixels, 1 extremes alternating, 2 with stray early reads and full loads
  task automatic run_frame(int unsigned r, int unsigned w, int unsigned h, int mode);
    int unsigned n;
    configure(r, w, h);
    n = eff_w() * eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      if (mode == 2 && $urandom_range(0, 9) == 0) send(sbb_pkg::OpRead, 24'($urandom));
      if (mode == 1) send(sbb_pkg::OpLoad, (i % 2) ? 24'hffffff : 24'h000000);
      else send(sbb_pkg::OpLoad, 24'($urandom));
    end
    if (mode == 2) repeat ($urandom_range(1, 3)) send(sbb_pkg::OpLoad, 24'($urandom));
    for (int unsigned i = 0; i < n; i++) begin
      if (mode == 2 && $urandom_range(0, 9) == 0) send(sbb_pkg::OpLoad, 24'($urandom));
      send(sbb_pkg::OpRead, 24'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (!in_valid_i || in_ready_o) begin
      if (pending_beats.size() != 0 && (quiet_now() || $urandom_range(0, 99) >= 12)) begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= quiet_now() || $urandom_range(0, 99) >= 12;
  end

  always @(posedge clk_i) begin
    sbb_pkg::out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected beat %p", out_data_o);
        error_count++;
      end else begin
        exp_item = expected_pixels.pop_front();
        if (out_data_o.status != exp_item.status) begin
          $error("status: expected %0d, got %0d", exp_item.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.out_red != exp_item.out_red) begin
          $error("out_red: expected %0d, got %0d", exp_item.out_red, out_data_o.out_red);
          error_count++;
        end
        if (out_data_o.out_green != exp_item.out_green) begin
          $error("out_green: expected %0d, got %0d", exp_item.out_green,
                 out_data_o.out_green);
          error_count++;
        end
        if (out_data_o.out_blue != exp_item.out_blue) begin
          $error("out_blue: expected %0d, got %0d", exp_item.out_blue, out_data_o.out_blue);
          error_count++;
        end
        if (out_data_o.last_pixel != exp_item.last_pixel) begin
          $error("last_pixel: expected %0d, got %0d", exp_item.last_pixel,
                 out_data_o.last_pixel);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset size is 64x64, so only check early reads before reconfiguring.
    send(sbb_pkg::OpRead, 24'hffffff);
    send(sbb_pkg::OpRead, 24'h000000);
    run_frame(0, 2, 2, 1);
    run_frame(1, 3, 2, 2);
    run_frame(31, 0, 0, 2);
    run_frame(31, 127, 1, 1);
    run_frame(31, 1, 127, 0);
    sent = 0;
    while (sent < 120) begin
      automatic int unsigned w = $urandom_range(1, 6);
      automatic int unsigned h = $urandom_range(1, 6);
      automatic int unsigned r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 3);
      run_frame(r, w, h, $urandom_range(0, 3) == 0 ? 2 : 0);
      sent += 2 * w * h;
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
